>>> rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the block bitmap allocator: command and
// status codes, map entry encodings and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // commands
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_ACCESS = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_DENIED   = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  // map entry encoding: free is all ones, allocated has bit 7 clear
  localparam logic [7:0] ENTRY_FREE = 8'hFF;
  localparam int         BIT_FREE   = 7;
  localparam int         BIT_RO     = 6;
  localparam int         OWNER_W    = 6;

  // field widths
  localparam int SIZE_W  = 21;
  localparam int BLK_W   = 8;
  localparam int ADDR_W  = 32;
  localparam int CFG_AW  = 2;

  // register byte addresses
  localparam logic [CFG_AW-1:0] REG_MEMORY_BASE = 2'd0;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_CHECK
  } bba_state_t;

endpackage

`default_nettype wire

>>> rtl/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram
// Block map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/block_bitmap_allocator.sv
// Zero-size allocate, reserved command and out-of-range index answer in the
//   cycle after start; free and access answer from S_CHECK (map read).
// Allocate scans the map one entry per cycle through the single read port and
//   then writes the run one entry per cycle.
// One item at a time; busy stays high until its result strobe.
// Reset: a clearing pass writes every map entry free, with busy high.
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit contiguous block allocator with per-block owner and read-only map.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_BYTES = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_command,
  input  wire logic [bba_pkg::SIZE_W-1:0]   in_size_bytes,
  input  wire logic [bba_pkg::OWNER_W-1:0]  in_owner_id,
  input  wire logic                         in_read_only_req,
  input  wire logic [bba_pkg::BLK_W-1:0]    in_target_block,
  // result channel
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [bba_pkg::BLK_W-1:0]         out_result_block,
  output logic [bba_pkg::ADDR_W-1:0]        out_result_address,
  output logic                              out_block_read_only,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bba_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  import bba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int RUN_W = $clog2((1 << SIZE_W) + BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [RUN_W-1:0] BB_RUN   = RUN_W'(BLOCK_BYTES);
  localparam logic [31:0]      NB_32    = 32'(NUM_BLOCKS);
  localparam logic [31:0]      BB_32    = 32'(BLOCK_BYTES);

  bba_state_t state_r, state_nxt;

  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic               last_r, last_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [RUN_W-1:0]   run_bytes_r, run_bytes_nxt;
  logic [IDX_W-1:0]   run_start_r, run_start_nxt;
  logic [IDX_W-1:0]   end_idx_r, end_idx_nxt;

  logic [1:0]         cmd_r, cmd_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic               ro_r, ro_nxt;
  logic [BLK_W-1:0]   tgt_r, tgt_nxt;

  logic [31:0]        base_r;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [BLK_W-1:0]   out_block_r, out_block_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic               out_ro_r, out_ro_nxt;

  // map port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [7:0]         ram_wdata;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [7:0]         ram_rdata;

  logic [31:0]        in_tgt_32;
  logic [31:0]        tgt_32;
  logic [31:0]        start_32;
  logic [RUN_W-1:0]   run_sum;
  logic               owned;

  assign in_tgt_32 = {{(32-BLK_W){1'b0}}, in_target_block};
  assign tgt_32    = {{(32-BLK_W){1'b0}}, tgt_r};
  assign start_32  = 32'(run_start_r);
  assign run_sum   = run_bytes_r + BB_RUN;
  assign owned     = !ram_rdata[BIT_FREE] && (ram_rdata[OWNER_W-1:0] == owner_r);

  bba_map_ram #(
    .DEPTH (NUM_BLOCKS),
    .AW    (IDX_W)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wdata   (ram_wdata),
    .rd_addr (ram_rd_addr),
    .rdata   (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    last_nxt       = last_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    run_bytes_nxt  = run_bytes_r;
    run_start_nxt  = run_start_r;
    end_idx_nxt    = end_idx_r;
    cmd_nxt        = cmd_r;
    size_nxt       = size_r;
    owner_nxt      = owner_r;
    ro_nxt         = ro_r;
    tgt_nxt        = tgt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_addr_nxt   = out_addr_r;
    out_ro_nxt     = out_ro_r;
    ram_we         = 1'b0;
    ram_wr_addr    = addr_r;
    ram_wdata      = ENTRY_FREE;
    ram_rd_addr    = addr_r;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        // fetch the target entry now so the check can run next cycle
        ram_rd_addr = in_tgt_32[IDX_W-1:0];
        if (start) begin
          cmd_nxt   = in_command;
          size_nxt  = in_size_bytes;
          owner_nxt = in_owner_id;
          ro_nxt    = in_read_only_req;
          tgt_nxt   = in_target_block;
          case (in_command)
            CMD_ALLOC: begin
              if (in_size_bytes == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_ZERO;
                out_block_nxt  = '0;
                out_addr_nxt   = '0;
                out_ro_nxt     = 1'b0;
              end else begin
                addr_nxt      = '0;
                last_nxt      = 1'b0;
                run_bytes_nxt = '0;
                run_start_nxt = '0;
                state_nxt     = S_SCAN;
              end
            end
            CMD_FREE, CMD_ACCESS: begin
              if (in_tgt_32 >= NB_32) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_RANGE;
                out_block_nxt  = in_target_block;
                out_addr_nxt   = '0;
                out_ro_nxt     = 1'b0;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RANGE;
              out_block_nxt  = '0;
              out_addr_nxt   = '0;
              out_ro_nxt     = 1'b0;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue side: one read per cycle until the last entry
        rd_vld_nxt = !last_r;
        rd_idx_nxt = addr_r;
        if (!last_r) begin
          if (addr_r == LAST_IDX) begin
            last_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        // check side: extend or break the current free run
        if (rd_vld_r) begin
          if (ram_rdata == ENTRY_FREE) begin
            if (run_sum >= RUN_W'(size_r)) begin
              end_idx_nxt = rd_idx_r;
              addr_nxt    = run_start_r;
              rd_vld_nxt  = 1'b0;
              state_nxt   = S_MARK;
            end else begin
              run_bytes_nxt = run_sum;
            end
          end else begin
            run_bytes_nxt = '0;
            run_start_nxt = rd_idx_r + 1'b1;
          end
          if (rd_idx_r == LAST_IDX && !(ram_rdata == ENTRY_FREE &&
                                         run_sum >= RUN_W'(size_r))) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NO_SPACE;
            out_block_nxt  = '0;
            out_addr_nxt   = '0;
            out_ro_nxt     = 1'b0;
            rd_vld_nxt     = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, ro_r, owner_r};
        if (addr_r == end_idx_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_block_nxt  = start_32[BLK_W-1:0];
          out_addr_nxt   = '0;
          out_ro_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      S_CHECK: begin
        out_valid_nxt = 1'b1;
        out_block_nxt = tgt_r;
        out_addr_nxt  = '0;
        out_ro_nxt    = 1'b0;
        state_nxt     = S_IDLE;
        if (!owned) begin
          out_status_nxt = ST_DENIED;
        end else if (cmd_r == CMD_FREE) begin
          ram_we         = 1'b1;
          ram_wr_addr    = tgt_32[IDX_W-1:0];
          ram_wdata      = ENTRY_FREE;
          out_status_nxt = ST_OK;
        end else begin
          out_status_nxt = ST_OK;
          out_addr_nxt   = base_r + tgt_32 * BB_32;
          out_ro_nxt     = ram_rdata[BIT_RO];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      last_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      last_r      <= last_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r     <= rd_idx_nxt;
    run_bytes_r  <= run_bytes_nxt;
    run_start_r  <= run_start_nxt;
    end_idx_r    <= end_idx_nxt;
    cmd_r        <= cmd_nxt;
    size_r       <= size_nxt;
    owner_r      <= owner_nxt;
    ro_r         <= ro_nxt;
    tgt_r        <= tgt_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ro_r     <= out_ro_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (psel && penable && pwrite && paddr == REG_MEMORY_BASE) begin
      base_r <= pwdata;
    end
  end

  assign prdata = (paddr == REG_MEMORY_BASE) ? base_r : '0;
  assign pready = 1'b1;

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_block    = out_block_r;
  assign out_result_address  = out_addr_r;
  assign out_block_read_only = out_ro_r;

endmodule

`default_nettype wire

>>> rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level assertions for the block bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [1:0]                   in_command,
  input wire logic [bba_pkg::SIZE_W-1:0]   in_size_bytes,
  input wire logic                         out_valid,
  input wire logic [2:0]                   out_status,
  input wire logic [bba_pkg::ADDR_W-1:0]   out_result_address,
  input wire logic                         out_block_read_only
);

  import bba_pkg::*;

  // reset starts the map clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low after reset");

  // a result word always ends the work, so the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_ZERO)
    else $error("illegal status code");

  // address and flag only on a granted word
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_result_address == '0 && !out_block_read_only)
    else $error("payload on failed word");

  // zero size is rejected right after the command
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_ALLOC && in_size_bytes == '0 |=>
      out_valid && out_status == ST_ZERO)
    else $error("zero size not rejected at once");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_command          (in_command),
  .in_size_bytes       (in_size_bytes),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_result_address  (out_result_address),
  .out_block_read_only (out_block_read_only)
);

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block bitmap allocator. A shadow of the block
// map predicts status, first block, address and read-only flag for every
// command word. Directed map corner cases come first, then random allocate,
// free and access churn under several memory base settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_BYTES = 4096;
  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_SIZE    = 1048576;
  localparam int PHASE_WORDS = 286;

  typedef struct {
    logic [1:0]        command;
    logic [SIZE_W-1:0] size_bytes;
    logic [5:0]        owner_id;
    logic              read_only_req;
    logic [BLK_W-1:0]  target_block;
  } cmd_word_t;

  typedef struct {
    logic [2:0]        status;
    logic [BLK_W-1:0]  result_block;
    logic [ADDR_W-1:0] result_address;
    logic              block_read_only;
  } alloc_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic [OWNER_W-1:0] in_owner_id = '0;
  logic in_read_only_req = 1'b0;
  logic [BLK_W-1:0] in_target_block = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [BLK_W-1:0] out_result_block;
  logic [ADDR_W-1:0] out_result_address;
  logic out_block_read_only;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [7:0]        map_shadow [NUM_BLOCKS];
  logic [ADDR_W-1:0] base_shadow = '0;
  alloc_outcome_t    expected_outcomes [$];

  int mismatch_count = 0;
  int outcomes_checked = 0;
  int commands_sent = 0;
  int base_writes = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int status_tally [5] = '{default: 0};

  always #(CLK_PERIOD / 2) clk = ~clk;

  block_bitmap_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_size_bytes      (in_size_bytes),
    .in_owner_id        (in_owner_id),
    .in_read_only_req   (in_read_only_req),
    .in_target_block    (in_target_block),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_block   (out_result_block),
    .out_result_address (out_result_address),
    .out_block_read_only(out_block_read_only),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  function automatic cmd_word_t mk_word(input logic [1:0] command,
                                        input logic [SIZE_W-1:0] size_bytes,
                                        input logic [5:0] owner_id,
                                        input logic read_only_req,
                                        input logic [BLK_W-1:0] target_block);
    cmd_word_t w;
    w.command       = command;
    w.size_bytes    = size_bytes;
    w.owner_id      = owner_id;
    w.read_only_req = read_only_req;
    w.target_block  = target_block;
    return w;
  endfunction

  // Advance the block map shadow by one command and return what it answers.
  function automatic alloc_outcome_t predict_outcome(input cmd_word_t w);
    alloc_outcome_t r;
    int need;
    int run;
    int first;
    logic [7:0] entry;
    r = '{ST_OK, '0, '0, 1'b0};
    if (w.command == CMD_ALLOC) begin
      if (w.size_bytes == '0) begin
        r.status = ST_ZERO;
      end else begin
        need  = (int'(w.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        first = -1;
        run   = 0;
        if (need <= NUM_BLOCKS) begin
          for (int i = 0; i < NUM_BLOCKS && first < 0; i++) begin
            run = (map_shadow[i] == ENTRY_FREE) ? run + 1 : 0;
            if (run == need) first = i + 1 - need;
          end
        end
        if (first < 0) begin
          r.status = ST_NO_SPACE;
        end else begin
          for (int k = first; k < first + need; k++) begin
            map_shadow[k] = {1'b0, w.read_only_req, w.owner_id};
          end
          r.result_block = BLK_W'(first);
        end
      end
    end else if (w.command == CMD_RSVD) begin
      r.status = ST_RANGE;
    end else begin
      r.result_block = w.target_block;
      if (int'(w.target_block) >= NUM_BLOCKS) begin
        r.status = ST_RANGE;
      end else begin
        entry = map_shadow[w.target_block];
        if (entry[BIT_FREE] || entry[OWNER_W-1:0] != w.owner_id) begin
          r.status = ST_DENIED;
        end else if (w.command == CMD_FREE) begin
          map_shadow[w.target_block] = ENTRY_FREE;
        end else begin
          r.result_address  = base_shadow + ADDR_W'(w.target_block) * ADDR_W'(BLOCK_BYTES);
          r.block_read_only = entry[BIT_RO];
        end
      end
    end
    return r;
  endfunction

  // Send one command word; returns at the edge that accepts it, start left high.
  task automatic issue_command(input cmd_word_t w);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= w.command;
    in_size_bytes    <= w.size_bytes;
    in_owner_id      <= w.owner_id;
    in_read_only_req <= w.read_only_req;
    in_target_block  <= w.target_block;
    do @(posedge clk); while (busy);
    expected_outcomes.push_back(predict_outcome(w));
    commands_sent++;
  endtask

  // Drop start and hold until every outstanding word has answered.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write memory_base, then read it back in a second transfer.
  task automatic write_memory_base(input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_MEMORY_BASE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    base_shadow = value;
    base_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      report_mismatch($sformatf("memory_base read %08h want %08h", prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return SIZE_W'($urandom_range(1, 8 * BLOCK_BYTES));
    if (roll < 80) return SIZE_W'($urandom_range(1, 16) * BLOCK_BYTES + $urandom_range(0, 1));
    if (roll < 95) return SIZE_W'($urandom_range(1, MAX_SIZE));
    return SIZE_W'(MAX_SIZE);
  endfunction

  // Mostly well-formed traffic on live blocks, with some noise mixed in.
  function automatic cmd_word_t pick_random_word();
    cmd_word_t w;
    int roll;
    int used;
    int alloc_share;
    int idx;
    int hit;
    w = mk_word(CMD_ALLOC, pick_size(), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    used = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) used += map_shadow[i][BIT_FREE] ? 0 : 1;
    alloc_share = (used < 64) ? 60 : (used < 160) ? 35 : 15;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      w.command = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) w.size_bytes = '0;
      return w;
    end
    if (roll < 8 + alloc_share || used == 0) return w;
    idx = $urandom_range(0, NUM_BLOCKS - 1);
    hit = -1;
    for (int i = 0; i < NUM_BLOCKS && hit < 0; i++) begin
      if (!map_shadow[(idx + i) % NUM_BLOCKS][BIT_FREE]) hit = (idx + i) % NUM_BLOCKS;
    end
    w.target_block = BLK_W'(hit);
    w.owner_id     = map_shadow[hit][OWNER_W-1:0];
    if ($urandom_range(0, 5) == 0) w.owner_id ^= 6'($urandom_range(1, 63));
    w.command = ($urandom_range(0, 9) < 6) ? CMD_FREE : CMD_ACCESS;
    return w;
  endfunction

  task automatic test_directed_map();
    wait_drained();
    write_memory_base(32'h0000_0000);
    issue_command(mk_word(CMD_ALLOC, 21'd0, 6'd0, 1'b0, 8'd0));
    // whole map in one run, then nothing fits
    issue_command(mk_word(CMD_ALLOC, 21'(MAX_SIZE), 6'd63, 1'b1, 8'd255));
    issue_command(mk_word(CMD_ALLOC, 21'd1, 6'd0, 1'b0, 8'd0));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd63, 1'b0, 8'd255));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd62, 1'b0, 8'd0));
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd0, 1'b0, 8'd0));
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd63, 1'b0, 8'd128));
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd63, 1'b0, 8'd128));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd63, 1'b0, 8'd128));
    issue_command(mk_word(CMD_ALLOC, 21'd4096, 6'd5, 1'b0, 8'd0));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd5, 1'b1, 8'd128));
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd63, 1'b0, 8'd129));
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd63, 1'b0, 8'd130));
    issue_command(mk_word(CMD_ALLOC, 21'd4097, 6'd1, 1'b1, 8'd0));
    issue_command(mk_word(CMD_ALLOC, 21'd4097, 6'd1, 1'b0, 8'd0));
    // single free slot at the top end of the map
    issue_command(mk_word(CMD_FREE, 21'd0, 6'd63, 1'b0, 8'd255));
    issue_command(mk_word(CMD_ALLOC, 21'd1, 6'd0, 1'b0, 8'd0));
    issue_command(mk_word(CMD_RSVD, 21'(MAX_SIZE), 6'd63, 1'b1, 8'd255));
    issue_command(mk_word(CMD_RSVD, 21'd0, 6'd0, 1'b0, 8'd0));
  endtask

  task automatic test_address_wrap();
    wait_drained();
    write_memory_base(32'hFFFF_FFFF);
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd0, 1'b0, 8'd255));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd63, 1'b0, 8'd0));
    issue_command(mk_word(CMD_ACCESS, 21'd0, 6'd1, 1'b0, 8'd129));
  endtask

  task automatic test_random_churn(input logic [31:0] base, input int words);
    wait_drained();
    write_memory_base(base);
    repeat (words) issue_command(pick_random_word());
  endtask

  always @(posedge clk) begin : outcome_check
    alloc_outcome_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d", out_status));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", out_status, want.status));
        if (out_result_block !== want.result_block)
          report_mismatch($sformatf("block %0d want %0d", out_result_block, want.result_block));
        if (out_result_address !== want.result_address)
          report_mismatch($sformatf("address %08h want %08h",
                                    out_result_address, want.result_address));
        if (out_block_read_only !== want.block_read_only)
          report_mismatch($sformatf("read only %0b want %0b",
                                    out_block_read_only, want.block_read_only));
      end
      outcomes_checked++;
      if (out_status <= ST_ZERO) status_tally[out_status]++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_outcomes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) map_shadow[i] = ENTRY_FREE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_map();
    test_address_wrap();
    test_random_churn(32'h8000_0000, PHASE_WORDS);
    test_random_churn($urandom, PHASE_WORDS);
    test_random_churn(32'hFFFF_F000, PHASE_WORDS);
    test_random_churn(32'h0000_0000, PHASE_WORDS);
    test_random_churn($urandom, PHASE_WORDS);
    wait_drained();
    // catch any stray strobe for the length of a full scan
    repeat (2 * NUM_BLOCKS + 8) @(posedge clk);
    $display("covered %0d command words over %0d memory_base settings, %0d results checked",
             commands_sent, base_writes, outcomes_checked);
    $display("statuses seen: ok %0d, no space %0d, range %0d, denied %0d, zero size %0d",
             status_tally[ST_OK], status_tally[ST_NO_SPACE], status_tally[ST_RANGE],
             status_tally[ST_DENIED], status_tally[ST_ZERO]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
